@@ design/zsw_pkg.sv @@
// Shared constants and types for the zero square window finder.
`timescale 1ns / 1ps

package zsw_pkg;

   // Field widths fixed by the register map and result format
   localparam int CSR_SIZE_W   = 11;
   localparam int WINDOW_W     = 7;
   localparam int CSR_INDEX_W  = 2;
   localparam int RUN_W        = 7;
   localparam int COUNT_W      = 21;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SIZE  = 2'd2;

   // Register reset values
   localparam logic [CSR_SIZE_W-1:0] FRAME_WIDTH_RESET  = 11'd8;
   localparam logic [CSR_SIZE_W-1:0] FRAME_HEIGHT_RESET = 11'd8;
   localparam logic [WINDOW_W-1:0]   WINDOW_SIZE_RESET  = 7'd2;

   // Saturation limits
   localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Default build limits
   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_MAX_HEIGHT = 1024;

   // Per-item pixel value and position flags from the scan counters
   typedef struct packed {
      logic pixel;
      logic first_row;
      logic row_end;
      logic frame_last;
   } tag_type;

endpackage

@@ design/zero_square_window_finder.sv @@
// Top level of the zero square window finder: registers, column store and pipeline.
`timescale 1ns / 1ps

// Streams a binary raster one pixel per item in row-major order and returns one
// result item per pixel: whether the window_size square ending at that pixel is
// all zero, the running case number for the frame and a frame-end flag. One item
// is accepted every clock cycle unless the result side stalls; a result is shown
// from the result register after its pixel leaves stage one. The rate is set by
// the single read-modify-write of the per-column zero-run memory per item, and a
// run written in the same cycle as a read of it is forwarded. The column store
// needs no reset clearing, as a frame's first row ignores it. Configuration takes
// effect on the next pixel; the user must write it only while idle (not enforced).
module zero_square_window_finder #(
   parameter int MAX_WIDTH  = zsw_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = zsw_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [zsw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [zsw_pkg::CSR_SIZE_W-1:0]  csr_write_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_window_found,
   output logic [zsw_pkg::COUNT_W-1:0]     rsp_case_number,
   output logic                            rsp_frame_end
);

   import zsw_pkg::*;

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic [CSR_SIZE_W-1:0] frame_width_ff, frame_width_in;
   logic [CSR_SIZE_W-1:0] frame_height_ff, frame_height_in;
   logic [WINDOW_W-1:0]   window_size_ff, window_size_in;

   logic             accept;
   logic [COL_W-1:0] column;
   tag_type          tag;
   logic             ram_wr_en;
   logic [COL_W-1:0] ram_wr_addr;
   logic [RUN_W-1:0] ram_wr_data, ram_rd_data;

   // Configuration registers
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      window_size_in  = window_size_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_write_data;
            CSR_FRAME_HEIGHT: frame_height_in = csr_write_data;
            CSR_WINDOW_SIZE:  window_size_in  = csr_write_data[WINDOW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         window_size_ff  <= WINDOW_SIZE_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         window_size_ff  <= window_size_in;
      end
   end

   assign accept = req_valid && req_ready;

   zsw_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .pixel        (req_pixel),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .column       (column),
      .tag          (tag)
   );

   // Per-column vertical zero-run store
   zsw_ram #(
      .WIDTH (RUN_W),
      .DEPTH (MAX_WIDTH)
   ) u_column_run (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (column),
      .rd_data (ram_rd_data)
   );

   zsw_count #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_count (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .column           (column),
      .tag              (tag),
      .window_size      (window_size_ff),
      .ram_rd_data      (ram_rd_data),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .in_ready         (req_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_window_found (rsp_window_found),
      .rsp_case_number  (rsp_case_number),
      .rsp_frame_end    (rsp_frame_end)
   );

endmodule

@@ design/zsw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module zsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/zsw_scan.sv @@
// Column and row position counters that tag each accepted item.
`timescale 1ns / 1ps

module zsw_scan #(
   parameter int MAX_WIDTH  = zsw_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = zsw_pkg::DEFAULT_MAX_HEIGHT,
   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic                            pixel,
   input  logic [zsw_pkg::CSR_SIZE_W-1:0]  frame_width,
   input  logic [zsw_pkg::CSR_SIZE_W-1:0]  frame_height,
   output logic [COL_W-1:0]                column,
   output zsw_pkg::tag_type                tag
);

   import zsw_pkg::*;

   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > CSR_SIZE_W) ?
                           $clog2(MAX_WIDTH + 1) : CSR_SIZE_W;
   localparam int HCMP_W = ($clog2(MAX_HEIGHT + 1) > CSR_SIZE_W) ?
                           $clog2(MAX_HEIGHT + 1) : CSR_SIZE_W;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [WCMP_W-1:0] eff_width, width_ext, col_next;
   logic [HCMP_W-1:0] eff_height, height_ext, row_next;

   // Effective frame sizes: zero acts as one, oversize clamps to the build limit
   always_comb begin
      width_ext  = WCMP_W'(frame_width);
      height_ext = HCMP_W'(frame_height);
      if (frame_width == '0) begin
         eff_width = WCMP_W'(1);
      end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
         eff_width = WCMP_W'(MAX_WIDTH);
      end else begin
         eff_width = width_ext;
      end
      if (frame_height == '0) begin
         eff_height = HCMP_W'(1);
      end else if (height_ext > HCMP_W'(MAX_HEIGHT)) begin
         eff_height = HCMP_W'(MAX_HEIGHT);
      end else begin
         eff_height = height_ext;
      end
   end

   // Tag for the item at the current position
   always_comb begin
      col_next       = WCMP_W'(col_ff) + WCMP_W'(1);
      row_next       = HCMP_W'(row_ff) + HCMP_W'(1);
      tag.pixel      = pixel;
      tag.first_row  = (row_ff == '0);
      tag.row_end    = (col_next >= eff_width);
      tag.frame_last = tag.row_end && (row_next >= eff_height);
      column         = col_ff;
   end

   // Advance the scan position on each accepted item
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (tag.frame_last) begin
            col_in = '0;
            row_in = '0;
         end else if (tag.row_end) begin
            col_in = '0;
            row_in = ROW_W'(row_next);
         end else begin
            col_in = COL_W'(col_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ design/zsw_count.sv @@
// Run update, window detection, case counter and result register.
`timescale 1ns / 1ps

module zsw_count #(
   parameter int MAX_WIDTH = zsw_pkg::DEFAULT_MAX_WIDTH,
   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [COL_W-1:0]              column,
   input  zsw_pkg::tag_type              tag,
   input  logic [zsw_pkg::WINDOW_W-1:0]  window_size,
   input  logic [zsw_pkg::RUN_W-1:0]     ram_rd_data,
   output logic                          ram_wr_en,
   output logic [COL_W-1:0]              ram_wr_addr,
   output logic [zsw_pkg::RUN_W-1:0]     ram_wr_data,
   output logic                          in_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_window_found,
   output logic [zsw_pkg::COUNT_W-1:0]   rsp_case_number,
   output logic                          rsp_frame_end
);

   import zsw_pkg::*;

   // Stage holding an item whose column run is being read
   logic              s1_valid_ff, s1_valid_in;
   tag_type           s1_tag_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic              byp_valid_ff;
   logic [RUN_W-1:0]  byp_run_ff;

   // Running state
   logic [RUN_W-1:0]   wide_ff, wide_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // Result register
   logic               out_valid_ff, out_valid_in;
   logic               out_found_ff;
   logic [COUNT_W-1:0] out_count_ff;
   logic               out_end_ff;

   logic               s1_move;
   logic [WINDOW_W-1:0] k;
   logic [RUN_W-1:0]   prev_run, run, wide_base, wide_next;
   logic [COUNT_W-1:0] count_next;
   logic               found;

   assign s1_move  = !out_valid_ff || rsp_ready;
   assign in_ready = !s1_valid_ff || s1_move;
   assign k        = (window_size == '0) ? WINDOW_W'(1) : window_size;

   // Column run, horizontal run and case count for the stage-one item
   always_comb begin
      prev_run = byp_valid_ff ? byp_run_ff : ram_rd_data;
      if (s1_tag_ff.pixel) begin
         run = '0;
      end else if (s1_tag_ff.first_row) begin
         run = RUN_W'(1);
      end else if (prev_run == RUN_MAX) begin
         run = RUN_MAX;
      end else begin
         run = prev_run + RUN_W'(1);
      end
      wide_base = (s1_col_ff == '0) ? '0 : wide_ff;
      if (run >= k) begin
         wide_next = (wide_base == RUN_MAX) ? RUN_MAX : wide_base + RUN_W'(1);
      end else begin
         wide_next = '0;
      end
      found = (wide_next >= k);
      if (found && count_ff != COUNT_MAX) begin
         count_next = count_ff + COUNT_W'(1);
      end else begin
         count_next = count_ff;
      end
   end

   // Write back the new column run as the item leaves stage one
   assign ram_wr_en   = s1_valid_ff && s1_move;
   assign ram_wr_addr = s1_col_ff;
   assign ram_wr_data = run;

   // State updates; row and frame ends clear the horizontal run, frame ends the count
   always_comb begin
      wide_in  = wide_ff;
      count_in = count_ff;
      if (ram_wr_en) begin
         if (s1_tag_ff.row_end) begin
            wide_in = '0;
         end else begin
            wide_in = wide_next;
         end
         if (s1_tag_ff.frame_last) begin
            count_in = '0;
         end else begin
            count_in = count_next;
         end
      end
   end

   // Stage and result valid flags
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (ram_wr_en) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         wide_ff      <= '0;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         wide_ff      <= wide_in;
         count_ff     <= count_in;
      end
   end

   // Stage-one payload; forward the run written in the same cycle as the read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tag_ff    <= tag;
         s1_col_ff    <= column;
         byp_valid_ff <= ram_wr_en && (s1_col_ff == column);
         byp_run_ff   <= run;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (ram_wr_en) begin
         out_found_ff <= found;
         out_count_ff <= count_next;
         out_end_ff   <= s1_tag_ff.frame_last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_window_found = out_found_ff;
   assign rsp_case_number  = out_count_ff;
   assign rsp_frame_end    = out_end_ff;

   // A found window always carries a non-zero case number
   a_found_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_window_found |-> rsp_case_number != '0)
      else $error("window reported with zero case number");

   // A set pixel always breaks the column run
   a_pixel_breaks_run: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en && s1_tag_ff.pixel |-> ram_wr_data == '0)
      else $error("set pixel left a non-zero column run");

   // Frame end returns the running state to zero
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en && s1_tag_ff.frame_last |=> count_ff == '0 && wide_ff == '0)
      else $error("running state not cleared at frame end");

   // An accepted item always occupies stage one next cycle
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item lost from stage one");

endmodule

@@ verif/zero_square_window_finder_tb.sv @@
// Self-checking testbench for the zero square window finder: predictor, stimulus and checks.
`timescale 1ns / 1ps

module zero_square_window_finder_tb;
   import zsw_pkg::*;

   localparam int MAX_COLS     = DEFAULT_MAX_WIDTH;
   localparam int MAX_ROWS     = DEFAULT_MAX_HEIGHT;
   localparam int RANDOM_ITEMS = 1850;
   localparam int QUIET_ITEMS  = 250;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 600000;

   typedef struct packed {
      logic               found;
      logic [COUNT_W-1:0] case_number;
      logic               frame_end;
   } window_result_type;

   // Scoreboard: mirrors the scan state and queues the result due for each pixel
   class square_window_board;
      logic [CSR_SIZE_W-1:0] frame_width;
      logic [CSR_SIZE_W-1:0] frame_height;
      logic [WINDOW_W-1:0]   window_size;
      logic [RUN_W-1:0]      column_run [MAX_COLS];
      logic [RUN_W-1:0]      wide_run;
      logic [9:0]            column;
      logic [9:0]            row;
      logic [COUNT_W-1:0]    found_count;
      int                    written_span;
      window_result_type     expected_windows [$];
      int                    fail_count;
      int                    results_checked;
      int                    windows_found;
      int                    frames_done;

      function new();
         frame_width     = FRAME_WIDTH_RESET;
         frame_height    = FRAME_HEIGHT_RESET;
         window_size     = WINDOW_SIZE_RESET;
         wide_run        = '0;
         column          = '0;
         row             = '0;
         found_count     = '0;
         written_span    = 0;
         fail_count      = 0;
         results_checked = 0;
         windows_found   = 0;
         frames_done     = 0;
      endfunction

      // Zero acts as one, anything above the build limit as the limit
      function int clamp_size(int value, int hi);
         if (value == 0) return 1;
         return (value > hi) ? hi : value;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_SIZE_W-1:0] data);
         case (idx)
            CSR_FRAME_WIDTH:  frame_width  = data;
            CSR_FRAME_HEIGHT: frame_height = data;
            CSR_WINDOW_SIZE:  window_size  = data[WINDOW_W-1:0];
            default: ;
         endcase
      endfunction

      function bit at_frame_start();
         return (column == 0) && (row == 0);
      endfunction

      // A new width mid-frame must not make a later row read a column never written
      function bit width_ok(int value);
         return (row == 0) || (clamp_size(value, MAX_COLS) <= written_span);
      endfunction

      function int pending();
         return expected_windows.size();
      endfunction

      // Work out the result for one accepted pixel and advance the scan
      function void note_pixel(logic pix);
         int                w;
         int                h;
         int                k;
         int                run;
         logic              row_end;
         logic              last;
         window_result_type r;
         w = clamp_size(frame_width, MAX_COLS);
         h = clamp_size(frame_height, MAX_ROWS);
         k = (window_size == 0) ? 1 : int'(window_size);
         if (pix) run = 0;
         else if (row == 0) run = 1;
         else begin
            run = int'(column_run[column]) + 1;
            if (run > int'(RUN_MAX)) run = int'(RUN_MAX);
         end
         column_run[column] = run[RUN_W-1:0];
         if (int'(column) + 1 > written_span) written_span = int'(column) + 1;

         // horizontal run of columns tall enough for the window
         if (column == 0) wide_run = '0;
         if (run >= k) begin
            if (wide_run != RUN_MAX) wide_run = wide_run + 1'b1;
         end else begin
            wide_run = '0;
         end
         r.found = (int'(wide_run) >= k);
         if (r.found && found_count != COUNT_MAX) found_count = found_count + 1'b1;

         row_end = (int'(column) + 1 >= w);
         last    = row_end && (int'(row) + 1 >= h);
         r.case_number = found_count;
         r.frame_end   = last;
         expected_windows.push_back(r);

         if (last) begin
            column      = '0;
            row         = '0;
            wide_run    = '0;
            found_count = '0;
         end else if (row_end) begin
            column   = '0;
            row      = row + 1'b1;
            wide_run = '0;
         end else begin
            column = column + 1'b1;
         end
      endfunction

      task report(string what, int got, int want);
         fail_count++;
         if (fail_count <= 40)
            $display("[%0t] mismatch on result %0d: %s got %0d, expected %0d",
                     $realtime, results_checked, what, got, want);
      endtask

      // Compare one accepted result with the oldest queued one
      task check_result(logic found, logic [COUNT_W-1:0] case_number, logic frame_end);
         window_result_type want;
         results_checked++;
         if (expected_windows.size() == 0) begin
            report("result with nothing queued, case_number", case_number, 0);
            return;
         end
         want = expected_windows.pop_front();
         if (found !== want.found) report("window_found", found, want.found);
         if (case_number !== want.case_number)
            report("case_number", case_number, want.case_number);
         if (frame_end !== want.frame_end) report("frame_end", frame_end, want.frame_end);
         if (want.found) windows_found++;
         if (want.frame_end) frames_done++;
      endtask
   endclass

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_SIZE_W-1:0]  csr_write_data   = '0;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic                   req_pixel        = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic                   rsp_window_found;
   logic [COUNT_W-1:0]     rsp_case_number;
   logic                   rsp_frame_end;

   bit req_idle_on   = 1'b1;
   bit rsp_idle_on   = 1'b1;
   bit long_hold_req = 1'b0;
   int one_chance    = 0;   // ones per 64 pixels
   int cycle_count   = 0;
   int csr_writes    = 0;
   int pixels_sent   = 0;

   square_window_board board = new();

   zero_square_window_finder i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_window_found (rsp_window_found),
      .rsp_case_number  (rsp_case_number),
      .rsp_frame_end    (rsp_frame_end)
   );

   always #1 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side: check each accepted item, random back-pressure, one long hold-off
   initial begin : result_side
      int gap_left;
      int hold_left;
      bit hold_done;
      gap_left  = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            board.check_result(rsp_window_found, rsp_case_number, rsp_frame_end);
         if (long_hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 19) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic random_pixel();
      return ($urandom_range(0, 63) < one_chance);
   endfunction

   // Offer one pixel, with an occasional gap first; returns on the accepting edge
   task automatic send_pixel(input logic pix);
      if (req_idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_pixel(pix);
      pixels_sent++;
   endtask

   // Stop offering and wait for every queued result
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input int value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value[CSR_SIZE_W-1:0];
      @(posedge clock);
      board.set_register(idx, value[CSR_SIZE_W-1:0]);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      csr_writes++;
   endtask

   task automatic set_frame(input int fw, input int fh, input int ws);
      drain();
      write_csr(CSR_FRAME_WIDTH, fw);
      write_csr(CSR_FRAME_HEIGHT, fh);
      write_csr(CSR_WINDOW_SIZE, ws);
   endtask

   task automatic finish_frame();
      while (!board.at_frame_start()) send_pixel(random_pixel());
   endtask

   // Stimulus
   initial begin : stimulus
      int densities [6];
      int directed_count;
      int phase;
      int fw;
      int fh;
      int ws;
      int fsize;
      int count;
      int mode;
      densities = '{0, 2, 6, 12, 24, 40};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // basic frame, every pixel value
      set_frame(3, 2, 1);
      send_pixel(1'b0);
      send_pixel(1'b1);
      send_pixel(1'b0);
      send_pixel(1'b0);
      send_pixel(1'b0);
      send_pixel(1'b1);

      // zero sizes act as one
      set_frame(0, 0, 0);
      send_pixel(1'b0);
      send_pixel(1'b1);

      // window larger than the frame
      set_frame(2, 2, 127);
      repeat (4) send_pixel(1'b0);

      // oversized width, then narrowed past the current column mid-row
      set_frame(2047, 2, 1);
      send_pixel(1'b0);
      send_pixel(1'b0);
      send_pixel(1'b1);
      send_pixel(1'b0);
      send_pixel(1'b0);
      drain();
      write_csr(CSR_FRAME_WIDTH, 4);
      repeat (5) send_pixel(1'b0);

      // oversized height, then cut short mid-frame
      set_frame(1, 2047, 2);
      repeat (3) send_pixel(1'b0);
      drain();
      write_csr(CSR_FRAME_HEIGHT, 1);
      send_pixel(1'b0);

      directed_count = pixels_sent;
      phase = 0;

      // random phases, whole frames mostly, some cut short
      while (pixels_sent - directed_count < RANDOM_ITEMS - QUIET_ITEMS) begin
         req_idle_on = ($urandom_range(0, 4) != 0);
         rsp_idle_on = ($urandom_range(0, 4) != 0);
         one_chance = densities[$urandom_range(0, 5)];

         case (phase)
            // receiver holds off while the sender keeps offering
            1: begin
               finish_frame();
               set_frame(16, 16, 3);
               req_idle_on = 1'b0;
               long_hold_req <= 1'b1;
               repeat (256) send_pixel(random_pixel());
               drain();
            end
            // widest row, horizontal run saturates, then narrowed mid-row
            3: begin
               finish_frame();
               set_frame(1024, 2, 1);
               one_chance = 0;
               repeat (300) send_pixel(random_pixel());
               drain();
               write_csr(CSR_FRAME_WIDTH, 8);
               finish_frame();
            end
            // tallest column, vertical run saturates, largest windows
            6: begin
               finish_frame();
               set_frame(1, 1024, 64);
               one_chance = 0;
               repeat (140) send_pixel(random_pixel());
               drain();
               write_csr(CSR_WINDOW_SIZE, 127);
               repeat (10) send_pixel(random_pixel());
               drain();
               write_csr(CSR_FRAME_HEIGHT, 2);
               finish_frame();
            end
            default: begin
               mode = $urandom_range(0, 9);
               if (mode <= 6) begin
                  fw = $urandom_range(1, 24);
                  fh = $urandom_range(1, 12);
                  ws = $urandom_range(1, 6);
               end else if (mode == 7) begin
                  fw = $urandom_range(25, 64);
                  fh = $urandom_range(1, 4);
                  ws = $urandom_range(1, 8);
               end else if (mode == 8) begin
                  fw = $urandom_range(1, 6);
                  fh = $urandom_range(1, 6);
                  ws = $urandom_range(7, 127);
               end else begin
                  fw = $urandom_range(0, 3);
                  fh = $urandom_range(0, 3);
                  ws = $urandom_range(0, 2);
               end
               if (phase == 0 || $urandom_range(0, 3) != 0) begin
                  if (!board.width_ok(fw)) finish_frame();
                  drain();
                  write_csr(CSR_FRAME_WIDTH, fw);
               end else begin
                  drain();
               end
               if ($urandom_range(0, 3) != 0) write_csr(CSR_FRAME_HEIGHT, fh);
               if ($urandom_range(0, 3) != 0) write_csr(CSR_WINDOW_SIZE, ws);

               fsize = board.clamp_size(board.frame_width, MAX_COLS) *
                       board.clamp_size(board.frame_height, MAX_ROWS);
               if ($urandom_range(0, 4) == 0) count = $urandom_range(1, fsize);
               else count = fsize * $urandom_range(1, 3);
               repeat (count) send_pixel(random_pixel());
            end
         endcase
         phase++;
      end

      // closing stretch with no idling on either side
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      one_chance  = densities[$urandom_range(0, 5)];
      repeat (QUIET_ITEMS) send_pixel(random_pixel());

      // closing drain and tail
      drain();
      repeat (10) @(posedge clock);
      if (board.pending() != 0) board.report("results still queued", board.pending(), 0);

      $display("Checked %0d results over %0d frames, %0d windows found, %0d register writes.",
               board.results_checked, board.frames_done, board.windows_found, csr_writes);
      $display("Sizes from zero to oversized, windows up to 127, long runs and mid-frame cuts.");
      if (board.fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", board.fail_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/zsw_pkg.sv
design/zsw_ram.sv
design/zsw_scan.sv
design/zsw_count.sv
design/zero_square_window_finder.sv
verif/zero_square_window_finder_tb.sv
